>>> src/brlc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brlc_pkg
// Shared constants and the command and status words between the byte-run
// line compressor controller and its datapath.
// ----------------------------------------------------------------------------
package brlc_pkg;

  localparam int MAX_PACKET_DEF = 127;  // longest run or literal packet
  localparam int RUN_MIN        = 3;    // shortest run sent as a run packet
  localparam int PACK_BYTES     = 8;    // bytes per output word
  localparam int BYTE_W         = 8;
  localparam int FILL_W         = 3;    // pack buffer fill, wraps at eight
  localparam int COUNT_W        = 4;    // byte_count field

  typedef struct packed {
    logic capture;    // take the accepted pixel
    logic inc_run;    // pixel extends the run
    logic set_run;    // pixel starts a new run
    logic add_lit;    // move one run byte into the literal store
    logic fl_start;   // push literal packet lead byte
    logic fl_push;    // push one stored literal
    logic run_cnt;    // push run length
    logic run_val;    // push run value
    logic emit_part;  // send partly filled word
    logic emit_hdr;   // send line header word
  } brlc_cmd_t;

  typedef struct packed {
    logic match;
    logic len_ge3;
    logic len_nz;
    logic len_max;
    logic lit_zero;
    logic lit_full_next;
    logic rd_last;
    logic fill_nz;
    logic can_push;
    logic out_free;
    logic line_end;
  } brlc_status_t;

endpackage

>>> src/brlc_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brlc_in_if
// Pixel input channel: one pixel byte and its end-of-line mark per word.
// ----------------------------------------------------------------------------
interface brlc_in_if;
  import brlc_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] pixel;
  logic              line_end;

  modport source (output valid, output pixel, output line_end, input ready);
  modport sink   (input valid, input pixel, input line_end, output ready);

endinterface

>>> src/brlc_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brlc_out_if
// Packed output channel: up to eight encoded bytes per word, with flags.
// ----------------------------------------------------------------------------
interface brlc_out_if;
  import brlc_pkg::*;

  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  out_byte_0;
  logic [BYTE_W-1:0]  out_byte_1;
  logic [BYTE_W-1:0]  out_byte_2;
  logic [BYTE_W-1:0]  out_byte_3;
  logic [BYTE_W-1:0]  out_byte_4;
  logic [BYTE_W-1:0]  out_byte_5;
  logic [BYTE_W-1:0]  out_byte_6;
  logic [BYTE_W-1:0]  out_byte_7;
  logic [COUNT_W-1:0] byte_count;
  logic               is_line_header;
  logic               last_of_line;

  modport source (
    output valid, output out_byte_0, output out_byte_1, output out_byte_2,
    output out_byte_3, output out_byte_4, output out_byte_5, output out_byte_6,
    output out_byte_7, output byte_count, output is_line_header,
    output last_of_line, input ready
  );
  modport sink (
    input valid, input out_byte_0, input out_byte_1, input out_byte_2,
    input out_byte_3, input out_byte_4, input out_byte_5, input out_byte_6,
    input out_byte_7, input byte_count, input is_line_header,
    input last_of_line, output ready
  );

endinterface

>>> src/brlc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brlc_ctrl
// Sequencer for the byte-run encoder: steps each pixel through run
// matching, run closing, literal packet flushing and end-of-line output.
// ----------------------------------------------------------------------------
module brlc_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  brlc_pkg::brlc_status_t st,
  output brlc_pkg::brlc_cmd_t    cmd
);
  import brlc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MATCH,
    S_SETRUN,
    S_CAP,
    S_END,
    S_FLEND,
    S_PART,
    S_HDR,
    S_CLOSE,
    S_ADDLIT,
    S_FL_HDR,
    S_FL_DATA,
    S_RUN_CNT,
    S_RUN_VAL
  } state_t;

  state_t state_r, state_nxt;
  state_t cr_ret_r, cr_ret_nxt;  // where a closed run resumes
  state_t fl_ret_r, fl_ret_nxt;  // where a literal flush resumes

  always_comb begin
    state_nxt  = state_r;
    cr_ret_nxt = cr_ret_r;
    fl_ret_nxt = fl_ret_r;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_MATCH;
        end
      end
      S_MATCH: begin
        if (st.match) begin
          cmd.inc_run = 1'b1;
          state_nxt   = S_CAP;
        end else begin
          cr_ret_nxt = S_SETRUN;
          state_nxt  = S_CLOSE;
        end
      end
      S_SETRUN: begin
        cmd.set_run = 1'b1;
        state_nxt   = S_END;
      end
      S_CAP: begin
        if (st.len_max) begin
          cr_ret_nxt = S_END;
          state_nxt  = S_CLOSE;
        end else begin
          state_nxt = S_END;
        end
      end
      S_END: begin
        if (st.line_end) begin
          cr_ret_nxt = S_FLEND;
          state_nxt  = S_CLOSE;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_FLEND: begin
        fl_ret_nxt = S_PART;
        state_nxt  = S_FL_HDR;
      end
      S_PART: begin
        if (!st.fill_nz) begin
          state_nxt = S_HDR;
        end else if (st.out_free) begin
          cmd.emit_part = 1'b1;
          state_nxt     = S_HDR;
        end
      end
      S_HDR: begin
        if (st.out_free) begin
          cmd.emit_hdr = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_CLOSE: begin
        if (st.len_ge3) begin
          fl_ret_nxt = S_RUN_CNT;
          state_nxt  = S_FL_HDR;
        end else if (st.len_nz) begin
          state_nxt = S_ADDLIT;
        end else begin
          state_nxt = cr_ret_r;
        end
      end
      S_ADDLIT: begin
        cmd.add_lit = 1'b1;
        if (st.lit_full_next) begin
          fl_ret_nxt = S_CLOSE;
          state_nxt  = S_FL_HDR;
        end else begin
          state_nxt = S_CLOSE;
        end
      end
      S_FL_HDR: begin
        if (st.lit_zero) begin
          state_nxt = fl_ret_r;
        end else if (st.can_push) begin
          cmd.fl_start = 1'b1;
          state_nxt    = S_FL_DATA;
        end
      end
      S_FL_DATA: begin
        if (st.can_push) begin
          cmd.fl_push = 1'b1;
          if (st.rd_last) begin
            state_nxt = fl_ret_r;
          end
        end
      end
      S_RUN_CNT: begin
        if (st.can_push) begin
          cmd.run_cnt = 1'b1;
          state_nxt   = S_RUN_VAL;
        end
      end
      S_RUN_VAL: begin
        if (st.can_push) begin
          cmd.run_val = 1'b1;
          state_nxt   = cr_ret_r;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cr_ret_r <= S_IDLE;
      fl_ret_r <= S_IDLE;
    end else begin
      state_r  <= state_nxt;
      cr_ret_r <= cr_ret_nxt;
      fl_ret_r <= fl_ret_nxt;
    end
  end

endmodule

>>> src/brlc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brlc_datapath
// Run tracker, literal store, packet counter, eight-byte pack buffer and
// output word register of the byte-run encoder.
// ----------------------------------------------------------------------------
module brlc_datapath #(
  parameter int MAX_PACKET = brlc_pkg::MAX_PACKET_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [brlc_pkg::BYTE_W-1:0] in_pixel,
  input  logic                        in_line_end,
  input  brlc_pkg::brlc_cmd_t          cmd,
  output brlc_pkg::brlc_status_t       st,
  brlc_out_if.source                  out_ch
);
  import brlc_pkg::*;

  localparam int CW = $clog2(MAX_PACKET + 1);  // run and literal counts
  localparam int AW = $clog2(MAX_PACKET);      // literal store index

  logic [BYTE_W-1:0]  pix_r;
  logic               le_r;
  logic [BYTE_W-1:0]  run_value_r;
  logic [CW-1:0]      run_len_r, run_len_nxt;
  logic [CW-1:0]      lit_cnt_r, lit_cnt_nxt;
  logic [BYTE_W-1:0]  pc_r, pc_nxt;
  logic [FILL_W-1:0]  fill_r, fill_nxt;
  logic [AW-1:0]      rd_idx_r, rd_addr;
  logic [BYTE_W-1:0]  rd_data_r;
  logic [BYTE_W-1:0]  lit_mem [MAX_PACKET];
  logic [BYTE_W-1:0]  pack_r [PACK_BYTES];

  logic               out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]  out_bytes_r [PACK_BYTES];
  logic [COUNT_W-1:0] out_count_r;
  logic               out_hdr_r;
  logic               out_last_r;

  logic               push;
  logic               emit_full;
  logic [BYTE_W-1:0]  push_b;

  // status
  assign st.match         = (run_len_r != '0) && (pix_r == run_value_r);
  assign st.len_ge3       = run_len_r >= CW'(RUN_MIN);
  assign st.len_nz        = run_len_r != '0;
  assign st.len_max       = run_len_r == CW'(MAX_PACKET);
  assign st.lit_zero      = lit_cnt_r == '0;
  assign st.lit_full_next = lit_cnt_r == CW'(MAX_PACKET - 1);
  assign st.rd_last       = (CW'(rd_idx_r) + CW'(1)) == lit_cnt_r;
  assign st.fill_nz       = fill_r != '0;
  assign st.out_free      = !out_valid_r || out_ch.ready;
  assign st.can_push      = (fill_r != FILL_W'(PACK_BYTES - 1)) || st.out_free;
  assign st.line_end      = le_r;

  assign push      = cmd.fl_start | cmd.fl_push | cmd.run_cnt | cmd.run_val;
  assign emit_full = push && (fill_r == FILL_W'(PACK_BYTES - 1));

  always_comb begin
    case (1'b1)
      cmd.fl_start: push_b = BYTE_W'(0) - BYTE_W'(lit_cnt_r);
      cmd.fl_push:  push_b = rd_data_r;
      cmd.run_cnt:  push_b = BYTE_W'(run_len_r);
      default:      push_b = run_value_r;
    endcase
  end

  // literal store read address
  always_comb begin
    if (cmd.fl_start) begin
      rd_addr = '0;
    end else if (cmd.fl_push && !st.rd_last) begin
      rd_addr = rd_idx_r + AW'(1);
    end else begin
      rd_addr = rd_idx_r;
    end
  end

  always_comb begin
    run_len_nxt = run_len_r;
    if (cmd.inc_run) begin
      run_len_nxt = run_len_r + CW'(1);
    end else if (cmd.set_run) begin
      run_len_nxt = CW'(1);
    end else if (cmd.add_lit) begin
      run_len_nxt = run_len_r - CW'(1);
    end else if (cmd.run_val || cmd.emit_hdr) begin
      run_len_nxt = '0;
    end

    lit_cnt_nxt = lit_cnt_r;
    if (cmd.add_lit) begin
      lit_cnt_nxt = lit_cnt_r + CW'(1);
    end else if ((cmd.fl_push && st.rd_last) || cmd.emit_hdr) begin
      lit_cnt_nxt = '0;
    end

    pc_nxt = pc_r;
    if ((cmd.fl_push && st.rd_last) || cmd.run_val) begin
      pc_nxt = pc_r + BYTE_W'(1);
    end else if (cmd.emit_hdr) begin
      pc_nxt = '0;
    end

    fill_nxt = fill_r;
    if (push) begin
      fill_nxt = fill_r + FILL_W'(1);
    end else if (cmd.emit_part || cmd.emit_hdr) begin
      fill_nxt = '0;
    end

    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (emit_full || cmd.emit_part || cmd.emit_hdr) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_value_r <= '0;
      run_len_r   <= '0;
      lit_cnt_r   <= '0;
      pc_r        <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.set_run) begin
        run_value_r <= pix_r;
      end
      run_len_r   <= run_len_nxt;
      lit_cnt_r   <= lit_cnt_nxt;
      pc_r        <= pc_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // literal store
  always_ff @(posedge clk) begin
    if (cmd.add_lit) begin
      lit_mem[lit_cnt_r[AW-1:0]] <= run_value_r;
    end
    rd_data_r <= lit_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pix_r <= in_pixel;
      le_r  <= in_line_end;
    end
    if (cmd.fl_start) begin
      rd_idx_r <= '0;
    end else if (cmd.fl_push && !st.rd_last) begin
      rd_idx_r <= rd_idx_r + AW'(1);
    end
    if (push) begin
      pack_r[fill_r] <= push_b;
    end
    if (emit_full) begin
      for (int i = 0; i < PACK_BYTES; i++) begin
        out_bytes_r[i] <= (i == PACK_BYTES - 1) ? push_b : pack_r[i];
      end
      out_count_r <= COUNT_W'(PACK_BYTES);
      out_hdr_r   <= 1'b0;
      out_last_r  <= 1'b0;
    end else if (cmd.emit_part) begin
      for (int i = 0; i < PACK_BYTES; i++) begin
        out_bytes_r[i] <= (FILL_W'(i) < fill_r) ? pack_r[i] : '0;
      end
      out_count_r <= COUNT_W'(fill_r);
      out_hdr_r   <= 1'b0;
      out_last_r  <= 1'b0;
    end else if (cmd.emit_hdr) begin
      for (int i = 0; i < PACK_BYTES; i++) begin
        out_bytes_r[i] <= (i == 0) ? pc_r : '0;
      end
      out_count_r <= COUNT_W'(1);
      out_hdr_r   <= 1'b1;
      out_last_r  <= 1'b1;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.out_byte_0     = out_bytes_r[0];
  assign out_ch.out_byte_1     = out_bytes_r[1];
  assign out_ch.out_byte_2     = out_bytes_r[2];
  assign out_ch.out_byte_3     = out_bytes_r[3];
  assign out_ch.out_byte_4     = out_bytes_r[4];
  assign out_ch.out_byte_5     = out_bytes_r[5];
  assign out_ch.out_byte_6     = out_bytes_r[6];
  assign out_ch.out_byte_7     = out_bytes_r[7];
  assign out_ch.byte_count     = out_count_r;
  assign out_ch.is_line_header = out_hdr_r;
  assign out_ch.last_of_line   = out_last_r;

endmodule

>>> src/byte_run_line_compressor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_run_line_compressor
// Byte-run line encoder: controller plus datapath.
// ----------------------------------------------------------------------------
// Pixels of one raster line come in one byte per word, line_end on the last.
// Runs of three or more equal bytes (up to MAX_PACKET) leave as a count and
// value pair, other bytes as literal packets led by the negated count, packed
// eight bytes to an output word; after the line's data comes a one-byte
// header word with the packet count mod 256 and last_of_line set, which
// downstream moves to the front of the line. One pixel is worked on at a
// time: a pixel that extends a run is counted and checked for a line end; one
// that starts a new run first closes the pending run, moving each short run
// byte to the literal store or, for a run of three or more, flushing the
// literals ahead of it and sending its run packet. A literal flush pushes the
// negated count, then the stored bytes into the single push path, one a cycle
// while pushes are not held; with nothing held it pushes nothing. A pixel that
// completes a full-length run also pays for closing it, and at a line end the
// run is closed, the literals flushed and the partial and header words sent.
// Output back-pressure holds any push that would complete a word, and the
// partial and header words, while the previous word is unread.
// ----------------------------------------------------------------------------
module byte_run_line_compressor #(
  parameter int MAX_PACKET = brlc_pkg::MAX_PACKET_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  brlc_in_if.sink    in_ch,
  brlc_out_if.source out_ch
);
  import brlc_pkg::*;

  brlc_cmd_t    cmd;
  brlc_status_t st;
  logic         in_ready;

  assign in_ch.ready = in_ready;

  brlc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  brlc_datapath #(
    .MAX_PACKET (MAX_PACKET)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_pixel    (in_ch.pixel),
    .in_line_end (in_ch.line_end),
    .cmd         (cmd),
    .st          (st),
    .out_ch      (out_ch)
  );

endmodule

>>> src/brlc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brlc_checker
// Port-level checks on the byte-run line encoder, bound to the top level.
// ----------------------------------------------------------------------------
module brlc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte_1,
  input logic [7:0] out_byte_7,
  input logic [3:0] byte_count,
  input logic       is_line_header,
  input logic       last_of_line
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(byte_count)
      && $stable(is_line_header))
    else $error("output word changed while stalled");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> byte_count >= 4'd1 && byte_count <= 4'd8)
    else $error("byte_count out of range");

  a_header_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (is_line_header == last_of_line)
      && (!is_line_header || (byte_count == 4'd1 && out_byte_1 == 8'd0)))
    else $error("malformed line header word");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && byte_count != 4'd8 |-> out_byte_7 == 8'd0)
    else $error("unused byte not zero");

  // one pixel in work at a time
  a_one_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("pixel taken while previous one in work");

endmodule

bind byte_run_line_compressor brlc_checker u_brlc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_byte_1     (out_ch.out_byte_1),
  .out_byte_7     (out_ch.out_byte_7),
  .byte_count     (out_ch.byte_count),
  .is_line_header (out_ch.is_line_header),
  .last_of_line   (out_ch.last_of_line)
);

>>> verif/byte_run_line_compressor_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_run_line_compressor_tb
// Self-checking bench for the byte-run line compressor.
// ----------------------------------------------------------------------------
// Pixel lines go in from a queue through a bursty clocked driver. Each accepted
// pixel is run through a behavioural encoder that queues the packed words it
// should produce. A clocked monitor with its own stall pattern takes words off
// the output channel and checks each field against the oldest queued word.
// Stimulus covers short hand-written lines, a full-length run, a full literal
// packet and random run-shaped lines.
// ----------------------------------------------------------------------------
module byte_run_line_compressor_tb;
  import brlc_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int TOTAL_ITEMS   = 360;
  localparam int SETTLE_CYCLES = 400;
  localparam int CYCLE_LIMIT   = 1000000;

  typedef struct packed {
    logic [BYTE_W-1:0] pixel;
    logic              line_end;
    logic              drain_first;
  } pixel_item_t;

  typedef struct packed {
    logic [PACK_BYTES-1:0][BYTE_W-1:0] data;
    logic [COUNT_W-1:0]                count;
    logic                              is_header;
    logic                              last;
  } packed_word_t;

  logic clk;
  logic rst_n;

  brlc_in_if  in_ch ();
  brlc_out_if out_ch ();

  byte_run_line_compressor i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  pixel_item_t  pixel_queue[$];
  packed_word_t expected_words[$];
  int           mismatch_count;
  int           cycle_count;

  // encoder state
  logic [BYTE_W-1:0]                 lit_store [0:MAX_PACKET_DEF-1];
  int                                lit_count;
  logic [BYTE_W-1:0]                 run_val;
  int                                run_len;
  logic [BYTE_W-1:0]                 pkt_count;
  logic [PACK_BYTES-1:0][BYTE_W-1:0] pack_buf;
  int                                pack_fill;

  // directed lines: {line_end, pixel}
  logic [8:0] directed_seq [0:22] = '{
    9'h100,
    9'h0FF, 9'h0FF, 9'h1FF,
    9'h05A, 9'h05A, 9'h1A5,
    9'h001, 9'h002, 9'h004, 9'h008, 9'h010, 9'h020, 9'h040, 9'h080, 9'h1FE,
    9'h080, 9'h080, 9'h080, 9'h080, 9'h17F,
    9'h07F, 9'h17F
  };

  function void queue_word(logic [PACK_BYTES-1:0][BYTE_W-1:0] data, int n, logic hdr);
    packed_word_t w;
    w = '0;
    for (int i = 0; i < n; i++) begin
      w.data[i] = data[i];
    end
    w.count     = COUNT_W'(n);
    w.is_header = hdr;
    w.last      = hdr;
    expected_words.push_back(w);
  endfunction

  function void pack_byte(logic [BYTE_W-1:0] b);
    pack_buf[pack_fill] = b;
    pack_fill++;
    if (pack_fill >= PACK_BYTES) begin
      queue_word(pack_buf, PACK_BYTES, 1'b0);
      pack_fill = 0;
    end
  endfunction

  function void send_literal_packet();
    if (lit_count == 0) return;
    pack_byte(BYTE_W'(256 - lit_count));
    for (int i = 0; i < lit_count; i++) begin
      pack_byte(lit_store[i]);
    end
    pkt_count++;
    lit_count = 0;
  endfunction

  function void hold_literal(logic [BYTE_W-1:0] b);
    lit_store[lit_count] = b;
    lit_count++;
    if (lit_count >= MAX_PACKET_DEF) send_literal_packet();
  endfunction

  function void close_pending_run();
    if (run_len >= RUN_MIN) begin
      send_literal_packet();
      pack_byte(BYTE_W'(run_len));
      pack_byte(run_val);
      pkt_count++;
    end else begin
      for (int i = 0; i < run_len; i++) begin
        hold_literal(run_val);
      end
    end
    run_len = 0;
  endfunction

  function void encode_pixel(logic [BYTE_W-1:0] px, logic line_end);
    logic [PACK_BYTES-1:0][BYTE_W-1:0] hdr;
    if (run_len > 0 && px == run_val) begin
      run_len++;
    end else begin
      close_pending_run();
      run_val = px;
      run_len = 1;
    end
    if (run_len >= MAX_PACKET_DEF) close_pending_run();
    if (line_end) begin
      close_pending_run();
      send_literal_packet();
      if (pack_fill > 0) queue_word(pack_buf, pack_fill, 1'b0);
      pack_fill = 0;
      hdr       = '0;
      hdr[0]    = pkt_count;
      queue_word(hdr, 1, 1'b1);
      pkt_count = '0;
      lit_count = 0;
      run_len   = 0;
    end
  endfunction

  task automatic add_pixel(logic [BYTE_W-1:0] px, logic line_end, logic drain);
    pixel_item_t item;
    item.pixel       = px;
    item.line_end    = line_end;
    item.drain_first = drain;
    pixel_queue.push_back(item);
  endtask

  // run-shaped line: segments of equal bytes, mostly short, no longer than room
  task automatic add_random_line(logic drain, int room);
    int         len;
    int         seg;
    int         pos;
    logic [7:0] val;
    len = ($urandom_range(0, 11) == 0) ? $urandom_range(100, 170) : $urandom_range(1, 20);
    if (len > room) len = room;
    pos = 0;
    while (pos < len) begin
      if ($urandom_range(0, 3) == 0) val = 8'($urandom_range(0, 3)) * 8'h55;
      else val = 8'($urandom);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: seg = 1;
        4, 5:       seg = 2;
        6, 7:       seg = $urandom_range(3, 6);
        8:          seg = $urandom_range(7, 16);
        default:    seg = (len >= 120 && $urandom_range(0, 1) == 0) ?
                          $urandom_range(120, 135) : $urandom_range(3, 4);
      endcase
      for (int k = 0; k < seg && pos < len; k++) begin
        add_pixel(val, pos == len - 1, drain && pos == 0);
        pos++;
      end
    end
  endtask

  task automatic check_field(string fld, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0h, got %0h", $time, fld, want, got);
      mismatch_count++;
    end
  endtask

  initial begin
    clk = 1'b0;
  end

  always begin
    #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // driver: bursts of random length with random gaps
  int burst_left;
  int gap_left;

  always @(posedge clk) begin
    pixel_item_t nxt;
    logic        take;
    if (!rst_n) begin
      in_ch.valid    <= 1'b0;
      in_ch.pixel    <= '0;
      in_ch.line_end <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) encode_pixel(in_ch.pixel, in_ch.line_end);
      if (!in_ch.valid || in_ch.ready) begin
        take = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pixel_queue.size() > 0) begin
          take = !(pixel_queue[0].drain_first && expected_words.size() != 0);
        end
        if (take) begin
          nxt = pixel_queue.pop_front();
          in_ch.valid    <= 1'b1;
          in_ch.pixel    <= nxt.pixel;
          in_ch.line_end <= nxt.line_end;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: calm and stall-heavy phases alternate
  int ready_phase;
  int stall_left;

  always @(posedge clk) begin
    packed_word_t got;
    packed_word_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      ready_phase = 0;
      stall_left  = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.data      = {out_ch.out_byte_7, out_ch.out_byte_6, out_ch.out_byte_5,
                         out_ch.out_byte_4, out_ch.out_byte_3, out_ch.out_byte_2,
                         out_ch.out_byte_1, out_ch.out_byte_0};
        got.count     = out_ch.byte_count;
        got.is_header = out_ch.is_line_header;
        got.last      = out_ch.last_of_line;
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word, expected none, got %0h", $time, got);
          mismatch_count++;
        end else begin
          want = expected_words.pop_front();
          for (int i = 0; i < PACK_BYTES; i++) begin
            check_field($sformatf("out_byte_%0d", i), want.data[i], got.data[i]);
          end
          check_field("byte_count", want.count, got.count);
          check_field("is_line_header", want.is_header, got.is_header);
          check_field("last_of_line", want.last, got.last);
        end
      end
      ready_phase++;
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (ready_phase[8] && $urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 10);
      end
    end
  end

  initial begin
    logic [7:0] lit_val;

    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.pixel    = '0;
    in_ch.line_end = 1'b0;
    out_ch.ready   = 1'b0;
    mismatch_count = 0;
    cycle_count    = 0;
    lit_count      = 0;
    run_val        = '0;
    run_len        = 0;
    pkt_count      = '0;
    pack_buf       = '0;
    pack_fill      = 0;

    foreach (directed_seq[i]) begin
      add_pixel(directed_seq[i][7:0], directed_seq[i][8], 1'b0);
    end
    // full run, then a fresh run of three
    for (int i = 0; i < 130; i++) begin
      add_pixel(8'h33, i == 129, 1'b0);
    end
    // full literal packet, a pair landing on the store limit
    for (int i = 0; i < 131; i++) begin
      lit_val = (i == 126) ? 8'(125 * 37) : 8'(i * 37);
      add_pixel(lit_val, i == 130, 1'b0);
    end
    add_random_line(1'b1, TOTAL_ITEMS - pixel_queue.size());
    while (pixel_queue.size() < TOTAL_ITEMS) begin
      add_random_line($urandom_range(0, 19) == 0, TOTAL_ITEMS - pixel_queue.size());
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (pixel_queue.size() != 0 || in_ch.valid) @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
